>>> design/soiir_pkg.sv
// Shared constants, default widths and register indexes of the biquad filter.
package soiir_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_WIDTH     = 16;
    localparam int COEF_FRAC_BITS = 14;

    // Width of the accumulator that the sum of products is kept in.
    localparam int ACC_WIDTH = 64;

    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_COEF_X0 = 3'd0,
        REG_COEF_X1 = 3'd1,
        REG_COEF_X2 = 3'd2,
        REG_COEF_Y1 = 3'd3,
        REG_COEF_Y2 = 3'd4
    } reg_index_t;

    // Reset values of the coefficients, trimmed to the coefficient width on use.
    localparam logic signed [31:0] COEF_X0_RESET = 32'sd4557;
    localparam logic signed [31:0] COEF_X1_RESET = 32'sd5913;
    localparam logic signed [31:0] COEF_X2_RESET = 32'sd5913;
    localparam logic signed [31:0] COEF_Y1_RESET = 32'sd5913;
    localparam logic signed [31:0] COEF_Y2_RESET = 32'sd5913;

endpackage

>>> design/soiir_datapath.sv
// Sum of products, rounding and saturation for one biquad sample.
module soiir_datapath #(
    parameter int SAMPLE_WIDTH   = soiir_pkg::SAMPLE_WIDTH,
    parameter int COEF_WIDTH     = soiir_pkg::COEF_WIDTH,
    parameter int COEF_FRAC_BITS = soiir_pkg::COEF_FRAC_BITS
) (
    input  logic signed [COEF_WIDTH-1:0]   coef_x0,
    input  logic signed [COEF_WIDTH-1:0]   coef_x1,
    input  logic signed [COEF_WIDTH-1:0]   coef_x2,
    input  logic signed [COEF_WIDTH-1:0]   coef_y1,
    input  logic signed [COEF_WIDTH-1:0]   coef_y2,
    input  logic signed [SAMPLE_WIDTH-1:0] x0,
    input  logic signed [SAMPLE_WIDTH-1:0] x1,
    input  logic signed [SAMPLE_WIDTH-1:0] x2,
    input  logic signed [SAMPLE_WIDTH-1:0] y1,
    input  logic signed [SAMPLE_WIDTH-1:0] y2,
    output logic signed [SAMPLE_WIDTH-1:0] y_out,
    output logic                           clip
);

    localparam int AW = soiir_pkg::ACC_WIDTH;
    localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
    // With this much headroom the five products and the rounding term can never
    // reach the accumulator limits, so a plain adder tree gives the same sum.
    localparam bit EXACT = (PW + 3) <= AW;

    localparam logic signed [AW-1:0] ACC_MAX  = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN  = {1'b1, {(AW-2){1'b0}}, 1'b1};
    localparam logic signed [AW-1:0] HALF     = AW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] SMAX     = (AW'(1) << (SAMPLE_WIDTH - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SMIN     = -(AW'(1) << (SAMPLE_WIDTH - 1));

    // Accumulator add that clamps to plus or minus the largest positive value.
    function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                    input logic signed [AW-1:0] b);
        logic signed [AW:0] s;
        logic signed [AW-1:0] r;
        s = {a[AW-1], a} + {b[AW-1], b};
        if (s[AW:AW-1] == 2'b01) begin
            r = ACC_MAX;
        end else if (s[AW] != s[AW-1] || (s[AW-1] && s[AW-2:0] == '0)) begin
            r = ACC_MIN;
        end else begin
            r = s[AW-1:0];
        end
        return r;
    endfunction

    logic signed [PW-1:0] p0, p1, p2, p3, p4;
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] y_full;

    always_comb begin
        p0 = $signed(PW'(coef_x0)) * $signed(PW'(x0));
        p1 = $signed(PW'(coef_x1)) * $signed(PW'(x1));
        p2 = $signed(PW'(coef_x2)) * $signed(PW'(x2));
        p3 = $signed(PW'(coef_y1)) * $signed(PW'(y1));
        p4 = $signed(PW'(coef_y2)) * $signed(PW'(y2));

        if (EXACT) begin
            acc = AW'(p0) + AW'(p1) + AW'(p2) + AW'(p3) + AW'(p4) + HALF;
        end else begin
            acc = sat_add(AW'(p0), AW'(p1));
            acc = sat_add(acc, AW'(p2));
            acc = sat_add(acc, AW'(p3));
            acc = sat_add(acc, AW'(p4));
            acc = sat_add(acc, HALF);
        end

        // Arithmetic shift floors, which with the half added rounds ties upwards.
        y_full = acc >>> COEF_FRAC_BITS;

        if (y_full > SMAX) begin
            y_out = SMAX[SAMPLE_WIDTH-1:0];
            clip  = 1'b1;
        end else if (y_full < SMIN) begin
            y_out = SMIN[SAMPLE_WIDTH-1:0];
            clip  = 1'b1;
        end else begin
            y_out = y_full[SAMPLE_WIDTH-1:0];
            clip  = 1'b0;
        end
    end

endmodule

>>> design/second_order_iir_filter_top.sv
// Top level of the direct-form-I biquad filter with stream ports and coefficient registers.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tdata: sample_in
//  m_        out        m_tvalid/m_tready  m_tdata: sample_out; m_tuser: clipped
//  cfg_      in         cfg_we             cfg_index, cfg_wdata: one coefficient
//
// One sample per cycle sustained while m_tready is high; a taken request passes through the
// input register, then the multiply-accumulate into the result register.
// The feedback of the previous output closes within the multiply-accumulate cycle.
// Reset is synchronous and active low; it empties both registers, clears the
// sample history and restores the coefficient defaults.
// While the result is stalled, one further request is still taken and held.
module second_order_iir_filter_top #(
    parameter int SAMPLE_WIDTH   = soiir_pkg::SAMPLE_WIDTH,
    parameter int COEF_WIDTH     = soiir_pkg::COEF_WIDTH,
    parameter int COEF_FRAC_BITS = soiir_pkg::COEF_FRAC_BITS,
    localparam int DATA_W        = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [DATA_W-1:0]                     s_tdata,   // sample_in
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [DATA_W-1:0]                     m_tdata,   // sample_out
    output logic [0:0]                            m_tuser,   // clipped
    input  logic                                  cfg_we,
    input  logic [soiir_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COEF_WIDTH-1:0]                 cfg_wdata
);

    logic signed [COEF_WIDTH-1:0]   coef_x0_reg, coef_x1_reg, coef_x2_reg;
    logic signed [COEF_WIDTH-1:0]   coef_y1_reg, coef_y2_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_sample_reg;
    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_in_1_reg, prev_in_2_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_out_1_reg, prev_out_2_reg;
    logic        [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_clip_reg;
    logic                           out_valid_reg;

    logic                           in_valid_next;
    logic                           out_valid_next;
    logic                           out_free;
    logic                           advance;
    logic                           s_take;
    logic signed [SAMPLE_WIDTH-1:0] y_calc;
    logic                           clip_calc;

    // The result register can be loaded when empty or being emptied this cycle.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    soiir_datapath #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .COEF_WIDTH    (COEF_WIDTH),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_datapath (
        .coef_x0(coef_x0_reg),
        .coef_x1(coef_x1_reg),
        .coef_x2(coef_x2_reg),
        .coef_y1(coef_y1_reg),
        .coef_y2(coef_y2_reg),
        .x0     (in_sample_reg),
        .x1     (prev_in_1_reg),
        .x2     (prev_in_2_reg),
        .y1     (prev_out_1_reg),
        .y2     (prev_out_2_reg),
        .y_out  (y_calc),
        .clip   (clip_calc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_x0_reg <= COEF_WIDTH'(soiir_pkg::COEF_X0_RESET);
            coef_x1_reg <= COEF_WIDTH'(soiir_pkg::COEF_X1_RESET);
            coef_x2_reg <= COEF_WIDTH'(soiir_pkg::COEF_X2_RESET);
            coef_y1_reg <= COEF_WIDTH'(soiir_pkg::COEF_Y1_RESET);
            coef_y2_reg <= COEF_WIDTH'(soiir_pkg::COEF_Y2_RESET);
        end else if (cfg_we) begin
            unique case (cfg_index)
                soiir_pkg::REG_COEF_X0: coef_x0_reg <= cfg_wdata;
                soiir_pkg::REG_COEF_X1: coef_x1_reg <= cfg_wdata;
                soiir_pkg::REG_COEF_X2: coef_x2_reg <= cfg_wdata;
                soiir_pkg::REG_COEF_Y1: coef_y1_reg <= cfg_wdata;
                soiir_pkg::REG_COEF_Y2: coef_y2_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_in_1_reg  <= '0;
            prev_in_2_reg  <= '0;
            prev_out_1_reg <= '0;
            prev_out_2_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                prev_in_2_reg  <= prev_in_1_reg;
                prev_in_1_reg  <= in_sample_reg;
                prev_out_2_reg <= prev_out_1_reg;
                prev_out_1_reg <= y_calc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_sample_reg <= s_tdata[SAMPLE_WIDTH-1:0];
        end
        if (advance) begin
            out_sample_reg <= y_calc;
            out_clip_reg   <= clip_calc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_sample_reg);
    assign m_tuser  = out_clip_reg;

endmodule

>>> design/soiir_checker.sv
// Port-level assertions for the biquad filter, bound to its top level.
module soiir_checker #(
    parameter int SAMPLE_WIDTH = soiir_pkg::SAMPLE_WIDTH,
    localparam int DATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [0:0]        m_tuser
);

    localparam logic [SAMPLE_WIDTH-1:0] SAT_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAT_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A clipped result sits on one of the two saturation bounds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[SAMPLE_WIDTH-1:0] == SAT_POS || m_tdata[SAMPLE_WIDTH-1:0] == SAT_NEG)
        else $error("clipped result is not a saturation bound");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // With no result waiting, a request is always taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

    // A fresh result follows a request that was taken earlier and passed through the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result appeared without a matching request");

endmodule

bind second_order_iir_filter_top soiir_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_soiir_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
